// ===== rtl/core/ppdn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdn_pkg
// Shared codes and sizes for the point pair distance and direction block.
// ----------------------------------------------------------------------------
package ppdn_pkg;

  typedef enum logic {
    CMD_EUCLID = 1'b0,
    CMD_L1     = 1'b1
  } ppdn_cmd_t;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

endpackage

// ===== rtl/core/ppdn_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdn_if
// Valid/ready channels for point pairs in and distance/direction results out.
// ----------------------------------------------------------------------------
interface ppdn_in_if #(
  parameter int COORD_BITS = 28
) ();
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] first_z;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] second_z;

  modport source (output valid, command, first_x, first_y, first_z,
                  second_x, second_y, second_z, input ready);
  modport sink   (input valid, command, first_x, first_y, first_z,
                  second_x, second_y, second_z, output ready);
endinterface

interface ppdn_out_if #(
  parameter int COORD_BITS = 28,
  parameter int FRAC_BITS  = 16
) ();
  logic                        valid;
  logic                        ready;
  logic [COORD_BITS:0]         distance;
  logic signed [FRAC_BITS+1:0] dir_x;
  logic signed [FRAC_BITS+1:0] dir_y;
  logic signed [FRAC_BITS+1:0] dir_z;
  logic                        coincident;

  modport source (output valid, distance, dir_x, dir_y, dir_z, coincident,
                  input ready);
  modport sink   (input valid, distance, dir_x, dir_y, dir_z, coincident,
                  output ready);
endinterface

// ===== rtl/core/ppdn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdn_front
// Takes point pairs, forms differences, magnitudes, squares and sums.
// ----------------------------------------------------------------------------
module ppdn_front #(
  parameter int COORD_BITS = 28
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ppdn_in_if.sink                   in_ch,
  output logic                      fr_valid,
  input  logic                      fr_ready,
  output logic                      fr_cmd,
  output logic [2:0]                fr_sgn,
  output logic [COORD_BITS:0]       fr_ax,
  output logic [COORD_BITS:0]       fr_ay,
  output logic [COORD_BITS:0]       fr_az,
  output logic [2*COORD_BITS+1:0]   fr_sq,
  output logic [COORD_BITS+1:0]     fr_asum
);
  localparam int DW  = COORD_BITS + 1;
  localparam int SQW = 2 * COORD_BITS + 2;

  logic en;

  // stage a: differences
  logic                 a_v_r;
  logic                 a_cmd_r;
  logic signed [DW-1:0] a_dx_r, a_dy_r, a_dz_r;
  logic signed [DW-1:0] dx_nxt, dy_nxt, dz_nxt;

  // stage b: magnitudes and squares
  logic              b_v_r;
  logic              b_cmd_r;
  logic [2:0]        b_sgn_r;
  logic [DW-1:0]     b_ax_r, b_ay_r, b_az_r;
  logic [SQW-1:0]    b_sx_r, b_sy_r, b_sz_r;
  logic [DW-1:0]     ax_nxt, ay_nxt, az_nxt;

  // stage c: sums
  logic              c_v_r;
  logic              c_cmd_r;
  logic [2:0]        c_sgn_r;
  logic [DW-1:0]     c_ax_r, c_ay_r, c_az_r;
  logic [SQW-1:0]    c_sq_r;
  logic [DW:0]       c_asum_r;

  assign en          = !c_v_r || fr_ready;
  assign in_ch.ready = en;

  assign dx_nxt = DW'(in_ch.second_x) - DW'(in_ch.first_x);
  assign dy_nxt = DW'(in_ch.second_y) - DW'(in_ch.first_y);
  assign dz_nxt = DW'(in_ch.second_z) - DW'(in_ch.first_z);

  // magnitude of the most negative difference still fits unsigned
  assign ax_nxt = a_dx_r[DW-1] ? DW'(-a_dx_r) : DW'(a_dx_r);
  assign ay_nxt = a_dy_r[DW-1] ? DW'(-a_dy_r) : DW'(a_dy_r);
  assign az_nxt = a_dz_r[DW-1] ? DW'(-a_dz_r) : DW'(a_dz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_ch.valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cmd_r  <= in_ch.command;
      a_dx_r   <= dx_nxt;
      a_dy_r   <= dy_nxt;
      a_dz_r   <= dz_nxt;

      b_cmd_r  <= a_cmd_r;
      b_sgn_r  <= {a_dz_r[DW-1], a_dy_r[DW-1], a_dx_r[DW-1]};
      b_ax_r   <= ax_nxt;
      b_ay_r   <= ay_nxt;
      b_az_r   <= az_nxt;
      b_sx_r   <= SQW'(ax_nxt) * SQW'(ax_nxt);
      b_sy_r   <= SQW'(ay_nxt) * SQW'(ay_nxt);
      b_sz_r   <= SQW'(az_nxt) * SQW'(az_nxt);

      c_cmd_r  <= b_cmd_r;
      c_sgn_r  <= b_sgn_r;
      c_ax_r   <= b_ax_r;
      c_ay_r   <= b_ay_r;
      c_az_r   <= b_az_r;
      c_sq_r   <= b_sx_r + b_sy_r + b_sz_r;
      c_asum_r <= (DW+1)'(b_ax_r) + (DW+1)'(b_ay_r) + (DW+1)'(b_az_r);
    end
  end

  assign fr_valid = c_v_r;
  assign fr_cmd   = c_cmd_r;
  assign fr_sgn   = c_sgn_r;
  assign fr_ax    = c_ax_r;
  assign fr_ay    = c_ay_r;
  assign fr_az    = c_az_r;
  assign fr_sq    = c_sq_r;
  assign fr_asum  = c_asum_r;

endmodule

// ===== rtl/core/ppdn_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdn_queue
// Small first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module ppdn_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             push, pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/ppdn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdn_back
// Pipelined square root, then three pipelined dividers and the output register.
// ----------------------------------------------------------------------------
module ppdn_back #(
  parameter int COORD_BITS = 28,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      bk_valid,
  output logic                      bk_ready,
  input  logic                      bk_cmd,
  input  logic [2:0]                bk_sgn,
  input  logic [COORD_BITS:0]       bk_ax,
  input  logic [COORD_BITS:0]       bk_ay,
  input  logic [COORD_BITS:0]       bk_az,
  input  logic [2*COORD_BITS+1:0]   bk_sq,
  input  logic [COORD_BITS+1:0]     bk_asum,
  ppdn_out_if.source                out_ch
);
  import ppdn_pkg::*;

  localparam int R   = COORD_BITS + 1;       // root bits
  localparam int SQW = 2 * R;                // radicand bits
  localparam int AW  = COORD_BITS + 1;       // magnitude bits
  localparam int VW  = COORD_BITS + 2;       // divisor bits
  localparam int QW  = FRAC_BITS + 1;        // quotient bits
  localparam int NW  = AW + FRAC_BITS;       // dividend bits
  localparam int TW  = VW + QW;              // compare width
  localparam int OW  = FRAC_BITS + 2;        // direction bits

  logic en;
  logic out_valid_r;
  logic coinc_r;
  logic [R-1:0] dist_r;
  logic signed [OW-1:0] dir_r [0:2];

  assign en       = !out_valid_r || out_ch.ready;
  assign bk_ready = en;

  // square root pipeline, one root bit per stage
  logic          sq_v_r    [0:R];
  logic          sq_cmd_r  [0:R];
  logic [2:0]    sq_sgn_r  [0:R];
  logic [AW-1:0] sq_a_r    [0:R][0:2];
  logic [VW-1:0] sq_asum_r [0:R];
  logic [SQW-1:0] sq_rad_r [0:R];
  logic [R+1:0]  sq_rem_r  [0:R];
  logic [R-1:0]  sq_root_r [0:R];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= bk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_cmd_r[0]  <= bk_cmd;
      sq_sgn_r[0]  <= bk_sgn;
      sq_a_r[0][0] <= bk_ax;
      sq_a_r[0][1] <= bk_ay;
      sq_a_r[0][2] <= bk_az;
      sq_asum_r[0] <= bk_asum;
      sq_rad_r[0]  <= bk_sq;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < R; k++) begin : g_sqrt
    logic [R+1:0] rem_sh, trial;
    logic         ge;

    assign rem_sh = {sq_rem_r[k][R-1:0], sq_rad_r[k][SQW-1 -: 2]};
    assign trial  = {sq_root_r[k], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_cmd_r[k+1]  <= sq_cmd_r[k];
        sq_sgn_r[k+1]  <= sq_sgn_r[k];
        sq_a_r[k+1]    <= sq_a_r[k];
        sq_asum_r[k+1] <= sq_asum_r[k];
        sq_rad_r[k+1]  <= sq_rad_r[k] << 2;
        sq_rem_r[k+1]  <= ge ? rem_sh - trial : rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][R-2:0], ge};
      end
    end
  end

  // divider pipeline, one quotient bit per stage in each of three lanes
  logic          dv_v_r    [0:QW];
  logic          dv_zero_r [0:QW];
  logic [2:0]    dv_sgn_r  [0:QW];
  logic [R-1:0]  dv_dist_r [0:QW];
  logic [VW-1:0] dv_div_r  [0:QW];
  logic [NW-1:0] dv_rem_r  [0:QW][0:2];
  logic [QW-1:0] dv_q_r    [0:QW][0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[R];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_zero_r[0] <= sq_asum_r[R] == '0;
      dv_sgn_r[0]  <= sq_sgn_r[R];
      dv_dist_r[0] <= sq_root_r[R];
      dv_div_r[0]  <= (sq_cmd_r[R] == CMD_L1) ? sq_asum_r[R] : VW'(sq_root_r[R]);
      for (int l = 0; l < 3; l++) begin
        dv_rem_r[0][l] <= NW'(sq_a_r[R][l]) << FRAC_BITS;
        dv_q_r[0][l]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [TW-1:0] shifted;

    assign shifted = TW'(dv_div_r[j]) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [TW-1:0] remx;
      logic          ge;

      assign remx = TW'(dv_rem_r[j][l]);
      assign ge   = remx >= shifted;

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[j+1][l] <= ge ? NW'(remx - shifted) : dv_rem_r[j][l];
          dv_q_r[j+1][l]   <= {dv_q_r[j][l][QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_zero_r[j+1] <= dv_zero_r[j];
        dv_sgn_r[j+1]  <= dv_sgn_r[j];
        dv_dist_r[j+1] <= dv_dist_r[j];
        dv_div_r[j+1]  <= dv_div_r[j];
      end
    end
  end

  // output register: sign, coincident masking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en && dv_v_r[QW]) begin
      coinc_r <= dv_zero_r[QW];
      dist_r  <= dv_dist_r[QW];
      for (int l = 0; l < 3; l++) begin
        if (dv_zero_r[QW]) begin
          dir_r[l] <= '0;
        end else if (dv_sgn_r[QW][l]) begin
          dir_r[l] <= -$signed({1'b0, dv_q_r[QW][l]});
        end else begin
          dir_r[l] <= $signed({1'b0, dv_q_r[QW][l]});
        end
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.distance   = dist_r;
  assign out_ch.dir_x      = dir_r[0];
  assign out_ch.dir_y      = dir_r[1];
  assign out_ch.dir_z      = dir_r[2];
  assign out_ch.coincident = coinc_r;

endmodule

// ===== rtl/core/point_pair_distance_normal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_pair_distance_normal
// Distance between two 3d points and the scaled direction from first to second.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  in_ch    sink       command, first_x/y/z, second_x/y/z
//  out_ch   source     distance, dir_x/y/z, coincident
//
//  one item per cycle sustained while the output is not held; each result
//  passes the front stages, the queue, the one-bit-per-stage square root
//  and dividers and the output register between input accept and valid
//  a four-entry queue separates the front from the back; the front stalls
//  only when the queue is full, the back only when the output is held
//  reset is synchronous and clears the valid bits and queue pointers
module point_pair_distance_normal #(
  parameter int COORD_BITS = 28,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ppdn_in_if.sink     in_ch,
  ppdn_out_if.source  out_ch
);
  import ppdn_pkg::*;

  localparam int AW  = COORD_BITS + 1;
  localparam int SQW = 2 * COORD_BITS + 2;
  localparam int VW  = COORD_BITS + 2;
  localparam int EW  = 1 + 3 + 3 * AW + SQW + VW;

  logic           fr_valid, fr_ready, fr_cmd;
  logic [2:0]     fr_sgn;
  logic [AW-1:0]  fr_ax, fr_ay, fr_az;
  logic [SQW-1:0] fr_sq;
  logic [VW-1:0]  fr_asum;

  logic           bk_valid, bk_ready, bk_cmd;
  logic [2:0]     bk_sgn;
  logic [AW-1:0]  bk_ax, bk_ay, bk_az;
  logic [SQW-1:0] bk_sq;
  logic [VW-1:0]  bk_asum;

  logic [EW-1:0]  push_data, pop_data;

  ppdn_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_cmd   (fr_cmd),
    .fr_sgn   (fr_sgn),
    .fr_ax    (fr_ax),
    .fr_ay    (fr_ay),
    .fr_az    (fr_az),
    .fr_sq    (fr_sq),
    .fr_asum  (fr_asum)
  );

  assign push_data = {fr_cmd, fr_sgn, fr_ax, fr_ay, fr_az, fr_sq, fr_asum};

  ppdn_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (push_data),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (pop_data)
  );

  assign {bk_cmd, bk_sgn, bk_ax, bk_ay, bk_az, bk_sq, bk_asum} = pop_data;

  ppdn_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .bk_valid (bk_valid),
    .bk_ready (bk_ready),
    .bk_cmd   (bk_cmd),
    .bk_sgn   (bk_sgn),
    .bk_ax    (bk_ax),
    .bk_ay    (bk_ay),
    .bk_az    (bk_az),
    .bk_sq    (bk_sq),
    .bk_asum  (bk_asum),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/core/ppdn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdn_checker
// Port-level checks on results of the point pair distance block.
// ----------------------------------------------------------------------------
module ppdn_checker #(
  parameter int COORD_BITS = 28,
  parameter int FRAC_BITS  = 16
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [COORD_BITS:0]         distance,
  input logic signed [FRAC_BITS+1:0] dir_x,
  input logic signed [FRAC_BITS+1:0] dir_y,
  input logic signed [FRAC_BITS+1:0] dir_z,
  input logic                        coincident
);
  localparam logic signed [FRAC_BITS+1:0] DIR_ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;
  localparam logic signed [FRAC_BITS+1:0] DIR_MIN = -DIR_ONE;

  // a held item keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(dir_x)
      && $stable(dir_y) && $stable(dir_z) && $stable(coincident))
    else $error("output item changed while stalled");

  a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && coincident |-> distance == '0 && dir_x == '0 && dir_y == '0
      && dir_z == '0)
    else $error("coincident item with nonzero distance or direction");

  a_dist_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !coincident |-> distance != '0)
    else $error("distinct points with zero distance");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> dir_x <= DIR_ONE && dir_x >= DIR_MIN && dir_y <= DIR_ONE
      && dir_y >= DIR_MIN && dir_z <= DIR_ONE && dir_z >= DIR_MIN)
    else $error("direction component beyond unit magnitude");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind point_pair_distance_normal ppdn_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_ppdn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .distance   (out_ch.distance),
  .dir_x      (out_ch.dir_x),
  .dir_y      (out_ch.dir_y),
  .dir_z      (out_ch.dir_z),
  .coincident (out_ch.coincident)
);
